[rtl/pmr_pkg.sv]
package pmr_pkg;

	// Sizing
	localparam int NUM_QUEUES = 8;
	localparam int RING_DEPTH = 32;
	localparam int MEM_DEPTH  = NUM_QUEUES * RING_DEPTH;
	localparam int QID_W      = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Request codes
	localparam logic REQ_SEND = 1'b0;
	localparam logic REQ_RECV = 1'b1;

	// Status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	typedef struct packed {
		logic        req_type;
		logic [15:0] queue_id;
		logic [15:0] msg_type;
		logic [31:0] msg_data;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        msg_valid;
		logic [2:0]  out_sender;
		logic [15:0] out_type;
		logic [31:0] out_data;
	} rsp_t;

	// One ring slot
	typedef struct packed {
		logic [2:0]  sender;
		logic [15:0] mtype;
		logic [31:0] data;
	} entry_t;

	// Controller -> datapath
	typedef struct packed {
		logic capture;
		logic look;
		logic take_read;
		logic load_out;
	} cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic read_ok;
		logic out_free;
	} stat_t;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(RING_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

endpackage

[rtl/per_queue_message_ring.sv]
// per_queue_message_ring
//
// Eight message queues, each a 32-slot ring holding at most 30 messages.
// Request channel (req_valid / req_stall / req): an item is taken on a rising
// edge with req_valid high and req_stall low. req_type selects send or
// receive, queue_id picks the ring; msg_type and msg_data matter for send.
// Response channel (rsp_valid / rsp_stall / rsp): exactly one item per request,
// in request order. status: ok, queue id out of range, full, or empty. A
// successful receive sets msg_valid and returns sender, type and data; all
// other responses carry zero message fields. A stored sender is the queue id.
// The response is loaded into the output register after the pointer lookup for
// send and for any failed request, and after the extra registered ring read for
// a successful receive. One request is in flight at a time, so a new item is
// accepted only once the controller walk through pointer lookup, ring read and
// response load is back in idle.
// A stalled response holds in the output register; the request side stays
// stalled only until that register can take the next result.
// Reset (arst_n low) empties every ring: read pointers go to 31, write pointers
// to 0, no response is pending. Ring contents are not cleared.
module per_queue_message_ring (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pmr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output pmr_pkg::rsp_t rsp
);
	import pmr_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencer: idle -> lookup -> (ring read) -> response load
	pmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// pointers, ring storage, result and output registers
	pmr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

[rtl/pmr_ctrl.sv]
module pmr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  pmr_pkg::stat_t stat,
	output pmr_pkg::cmd_t  cmd
);
	import pmr_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_LOOK = 4'b0010,
		S_READ = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_LOOK;
			end
			S_LOOK: begin
				state_d = stat.read_ok ? S_READ : S_DONE;
			end
			S_READ: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign req_stall     = (state_q != S_IDLE);
	assign cmd.capture   = (state_q == S_IDLE) && req_valid;
	assign cmd.look      = (state_q == S_LOOK);
	assign cmd.take_read = (state_q == S_READ);
	assign cmd.load_out  = (state_q == S_DONE) && stat.out_free;

endmodule

[rtl/pmr_dp.sv]
module pmr_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  pmr_pkg::req_t  req,
	input  pmr_pkg::cmd_t  cmd,
	output pmr_pkg::stat_t stat,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output pmr_pkg::rsp_t  rsp
);
	import pmr_pkg::*;

	req_t             req_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	entry_t           mem [MEM_DEPTH];
	entry_t           rdata_q;
	logic [PTR_W-1:0] rp_q [NUM_QUEUES];
	logic [PTR_W-1:0] wp_q [NUM_QUEUES];

	logic [QID_W-1:0]  qidx;
	logic              in_range;
	logic              is_send;
	logic [PTR_W-1:0]  rp, wp, rp_nxt, wp_nxt;
	logic              full, empty, send_ok, recv_ok;
	logic [ADDR_W-1:0] base, waddr, raddr;
	entry_t            wentry;
	logic [1:0]        look_status;
	rsp_t              look_res;

	always_ff @(posedge clk) begin
		if (cmd.capture) req_q <= req;
	end

	assign qidx     = req_q.queue_id[QID_W-1:0];
	assign in_range = (req_q.queue_id < 16'(NUM_QUEUES));
	assign is_send  = (req_q.req_type == REQ_SEND);
	assign rp       = rp_q[qidx];
	assign wp       = wp_q[qidx];
	assign rp_nxt   = ring_next(rp);
	assign wp_nxt   = ring_next(wp);
	assign full     = (wp_nxt == rp);
	assign empty    = (rp_nxt == wp);
	assign send_ok  = in_range && is_send && !full;
	assign recv_ok  = in_range && !is_send && !empty;

	// slot address = queue * depth + pointer
	assign base  = ADDR_W'(qidx) * ADDR_W'(RING_DEPTH);
	assign waddr = base + ADDR_W'(wp);
	assign raddr = base + ADDR_W'(rp_nxt);

	assign wentry.sender = req_q.queue_id[2:0];
	assign wentry.mtype  = req_q.msg_type;
	assign wentry.data   = req_q.msg_data;

	always_comb begin
		if (!in_range) begin
			look_status = ST_RANGE;
		end else if (is_send) begin
			look_status = full ? ST_FULL : ST_OK;
		end else begin
			look_status = empty ? ST_EMPTY : ST_OK;
		end
	end

	// status only, message fields zero
	always_comb begin
		look_res        = '0;
		look_res.status = look_status;
	end

	// ring storage
	always_ff @(posedge clk) begin
		if (cmd.look && send_ok) mem[waddr] <= wentry;
		if (cmd.look) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_QUEUES; i++) begin
				rp_q[i] <= PTR_W'(RING_DEPTH - 1);
				wp_q[i] <= '0;
			end
		end else if (cmd.look) begin
			if (send_ok) wp_q[qidx] <= wp_nxt;
			if (recv_ok) rp_q[qidx] <= rp_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.look) begin
			res_q <= look_res;
		end else if (cmd.take_read) begin
			res_q.msg_valid  <= 1'b1;
			res_q.out_sender <= rdata_q.sender;
			res_q.out_type   <= rdata_q.mtype;
			res_q.out_data   <= rdata_q.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) rsp_q <= res_q;
	end

	assign stat.read_ok  = recv_ok;
	assign stat.out_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid     = rsp_valid_q;
	assign rsp           = rsp_q;

endmodule

[rtl/pmr_checker.sv]
module pmr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input pmr_pkg::rsp_t rsp
);
	import pmr_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	// only one request in flight
	a_one_inflight: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("second request taken while one is in flight");

	// a returned message only comes with ok status
	a_msg_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.msg_valid |-> rsp.status == ST_OK)
		else $error("message returned with error status");

	// no message means zeroed message fields
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.msg_valid |->
			rsp.out_sender == 3'd0 && rsp.out_type == 16'd0 && rsp.out_data == 32'd0)
		else $error("message fields set without a message");

endmodule

bind per_queue_message_ring pmr_checker u_pmr_checker (.*);

[dv/per_queue_message_ring_tb.sv]
`timescale 1ns / 1ps

// Checks the per-queue message rings against a cycle-free predictor:
// every accepted request pushes one predicted response, and every accepted
// response is compared with the oldest prediction.
module per_queue_message_ring_tb;
	import pmr_pkg::*;

	// No acceptance on either channel for this many cycles ends the run.
	localparam int WATCHDOG_LIMIT = 5000;
	// Wait after the last prediction is matched; give the block a little more at the end.
	localparam int DRAIN_CYCLES   = 10;
	localparam int SHOWN_ERRORS   = 10;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_stall;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_stall = 1'b0;
	rsp_t  rsp;

	always #5 clk = ~clk;

	per_queue_message_ring uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	// Predictor state: ring contents plus last-read / next-write per queue.
	entry_t           ring_slot [NUM_QUEUES][RING_DEPTH];
	logic [PTR_W-1:0] rd_ptr    [NUM_QUEUES];
	logic [PTR_W-1:0] wr_ptr    [NUM_QUEUES];

	// Predicted responses, oldest first.
	rsp_t pending_rsp[$];

	// Idling knobs, in percent per cycle.
	int send_idle_pct = 0;
	int rsp_stall_pct = 0;

	int error_count = 0;
	int idle_cycles = 0;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	// Applies one request to the predictor state and returns its response.
	function automatic rsp_t predict_response(input req_t r);
		rsp_t             o;
		logic [QID_W-1:0] q;
		logic [PTR_W-1:0] nxt;
		o        = '0;
		o.status = ST_OK;
		if (r.queue_id >= 16'(NUM_QUEUES)) begin
			o.status = ST_RANGE;
		end else begin
			q = r.queue_id[QID_W-1:0];
			if (r.req_type == REQ_SEND) begin
				// full: one slot always separates the pointers
				nxt = wrap_inc(wr_ptr[q]);
				if (nxt == rd_ptr[q]) begin
					o.status = ST_FULL;
				end else begin
					ring_slot[q][wr_ptr[q]].sender = 3'(r.queue_id);
					ring_slot[q][wr_ptr[q]].mtype  = r.msg_type;
					ring_slot[q][wr_ptr[q]].data   = r.msg_data;
					wr_ptr[q] = nxt;
				end
			end else begin
				nxt = wrap_inc(rd_ptr[q]);
				if (nxt == wr_ptr[q]) begin
					o.status = ST_EMPTY;
				end else begin
					rd_ptr[q] = nxt;
					o.msg_valid  = 1'b1;
					o.out_sender = ring_slot[q][nxt].sender;
					o.out_type   = ring_slot[q][nxt].mtype;
					o.out_data   = ring_slot[q][nxt].data;
				end
			end
		end
		return o;
	endfunction

	task automatic report(input string msg);
		error_count++;
		if (error_count <= SHOWN_ERRORS) begin
			$display("%s", msg);
		end
	endtask

	// Sends one item: optional idle gap, then hold valid until accepted.
	// Called right after a rising edge; valid is only written once per step.
	task automatic send_item(input logic kind, input logic [15:0] qid,
			input logic [15:0] mtype, input logic [31:0] mdata);
		int   gap;
		req_t item;
		item.req_type = kind;
		item.queue_id = qid;
		item.msg_type = mtype;
		item.msg_data = mdata;
		gap = 0;
		while (gap < 50 && $urandom_range(99) < send_idle_pct) begin
			gap++;
		end
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		// stall is sampled as it was just before the edge
		do @(posedge clk); while (req_stall);
		pending_rsp.push_back(predict_response(item));
	endtask

	// Response side: check each accepted item, then pick next cycle's stall.
	always @(posedge clk) begin : check_responses
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_rsp.size() == 0) begin
				report($sformatf("unexpected response: status=%0d valid=%0d sender=%0d type=%h data=%h",
					rsp.status, rsp.msg_valid, rsp.out_sender, rsp.out_type, rsp.out_data));
			end else begin
				want = pending_rsp.pop_front();
				if (rsp.status !== want.status || rsp.msg_valid !== want.msg_valid ||
						rsp.out_sender !== want.out_sender ||
						rsp.out_type !== want.out_type || rsp.out_data !== want.out_data) begin
					report($sformatf({"mismatch: exp status=%0d valid=%0d sender=%0d type=%h",
						" data=%h, got status=%0d valid=%0d sender=%0d type=%h data=%h"},
						want.status, want.msg_valid, want.out_sender, want.out_type,
						want.out_data, rsp.status, rsp.msg_valid, rsp.out_sender,
						rsp.out_type, rsp.out_data));
				end
			end
		end
		rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
	end

	// Watchdog: counts cycles without any handshake on either channel.
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("per_queue_message_ring_tb: errors");
			$finish;
		end
	end

	// Field extremes, every request kind, out-of-range ids, empty receives.
	task automatic test_directed();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		send_item(REQ_RECV, 16'd5, 16'hFFFF, 32'hFFFF_FFFF);   // empty right after reset
		send_item(REQ_SEND, 16'd0, 16'h0000, 32'h0000_0000);
		send_item(REQ_SEND, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(REQ_RECV, 16'd0, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(REQ_RECV, 16'd0, 16'h0000, 32'h0000_0000);   // drained again
		send_item(REQ_SEND, 16'd7, 16'h1234, 32'hA5A5_A5A5);
		send_item(REQ_SEND, 16'd1, 16'hFFFF, 32'h0000_0000);
		send_item(REQ_SEND, 16'd2, 16'h0000, 32'hFFFF_FFFF);
		send_item(REQ_RECV, 16'd7, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'd2, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'd1, 16'h0000, 32'h0000_0000);
		// ids just past the last queue and at the top of the field
		send_item(REQ_SEND, 16'd8, 16'hBEEF, 32'h1234_5678);
		send_item(REQ_SEND, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_item(REQ_RECV, 16'd8, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'hFFFF, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'h8000, 16'h0000, 32'h0000_0000);
		send_item(REQ_RECV, 16'd4, 16'h0000, 32'h0000_0000);
	endtask

	// Fill one queue until full, drain it past empty; the second round
	// wraps both pointers around the ring.
	task automatic test_full_and_empty();
		send_idle_pct = 35;
		rsp_stall_pct = 35;
		for (int round = 0; round < 2; round++) begin
			for (int i = 0; i < RING_DEPTH - 1; i++) begin
				send_item(REQ_SEND, 16'd3, 16'($urandom), $urandom);
			end
			for (int i = 0; i < RING_DEPTH - 1; i++) begin
				send_item(REQ_RECV, 16'd3, 16'($urandom), $urandom);
			end
		end
	endtask

	// Chunks of traffic aimed mostly at one hot queue, with a send bias
	// that either fills it, drains it, or keeps it hovering.
	task automatic random_traffic(input int count);
		int          hot;
		int          send_pct;
		int          pick;
		logic        kind;
		logic [15:0] qid;
		hot      = 0;
		send_pct = 50;
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0) begin
				hot = $urandom_range(NUM_QUEUES - 1);
				case ($urandom_range(2))
					0: begin
						send_pct = 15;
					end
					1: begin
						send_pct = 50;
					end
					default: begin
						send_pct = 88;
					end
				endcase
			end
			pick = $urandom_range(99);
			if (pick < 8) begin
				qid = 16'($urandom_range(65535, NUM_QUEUES));
			end else if (pick < 80) begin
				qid = 16'(hot);
			end else begin
				qid = 16'($urandom_range(NUM_QUEUES - 1));
			end
			kind = ($urandom_range(99) < send_pct) ? REQ_SEND : REQ_RECV;
			send_item(kind, qid, 16'($urandom), $urandom);
		end
	endtask

	task automatic test_back_to_back();
		send_idle_pct = 0;
		rsp_stall_pct = 0;
		random_traffic(350);
	endtask

	task automatic test_sparse_requests();
		send_idle_pct = 82;
		rsp_stall_pct = 0;
		random_traffic(350);
	endtask

	task automatic test_slow_consumer();
		send_idle_pct = 0;
		rsp_stall_pct = 82;
		random_traffic(350);
	endtask

	task automatic test_mixed_idling();
		send_idle_pct = 35;
		rsp_stall_pct = 35;
		random_traffic(350);
	endtask

	initial begin
		for (int q = 0; q < NUM_QUEUES; q++) begin
			rd_ptr[q] = PTR_W'(RING_DEPTH - 1);
			wr_ptr[q] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_full_and_empty();
		test_back_to_back();
		test_sparse_requests();
		test_slow_consumer();
		test_mixed_idling();
		req_valid <= 1'b0;

		// the watchdog ends the run if responses stop coming
		while (pending_rsp.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0 && pending_rsp.size() == 0) begin
			$display("per_queue_message_ring_tb: clean");
		end else begin
			$display("per_queue_message_ring_tb: errors");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/pmr_pkg.sv
rtl/pmr_ctrl.sv
rtl/pmr_dp.sv
rtl/per_queue_message_ring.sv
rtl/pmr_checker.sv
dv/per_queue_message_ring_tb.sv
